### rtl/core/vrbs_pkg.sv
// Shared types and constants for the variable record byte stack.
`default_nettype none

package vrbs_pkg;

    localparam int OPCODE_W = 3;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 11;

    // Operation codes; unused codes behave as a status query.
    localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_POP    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_STATUS = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_PCHK  = 10'b00_0000_0010,
        S_PBYTE = 10'b00_0000_0100,
        S_TRL   = 10'b00_0000_1000,
        S_RD0   = 10'b00_0001_0000,
        S_RD1   = 10'b00_0010_0000,
        S_RD2   = 10'b00_0100_0000,
        S_RD3   = 10'b00_1000_0000,
        S_RD4   = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } state_t;

endpackage

`default_nettype wire

### rtl/core/vrbs_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface vrbs_in_if import vrbs_pkg::*;;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [BYTE_W-1:0]   data_byte;
    logic [COUNT_W-1:0]  byte_count;

    modport source (output valid, output opcode, output data_byte, output byte_count,
                    input ready);
    modport sink   (input valid, input opcode, input data_byte, input byte_count,
                    output ready);
endinterface

interface vrbs_out_if import vrbs_pkg::*;;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic                is_empty;
    logic [FREE_W-1:0]   free_bytes;

    modport source (output valid, output out_byte, output byte_valid, output last,
                    output status, output is_empty, output free_bytes, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input last,
                    input status, input is_empty, input free_bytes, output ready);
endinterface

`default_nettype wire

### rtl/core/variable_record_byte_stack.sv
// Top level of the variable record byte stack: sequencer, byte store and result register.
// A LIFO of variable-length byte records held in one single-port-write byte store. A record
// sits as its payload followed by a TRAILER_BYTES trailer (length byte, then zeros). Push
// bytes arrive one per transfer; the first byte of a record passes a fit check, then its
// write, later bytes go straight to their write, and the closing byte adds TRAILER_BYTES
// trailer writes before the result is posted. Pop and peek read and clip the trailer, then
// copy each byte by a store read, then a result load, through the one registered read
// port. Clear and status queries go straight to posting their result. Fit checks, trailer
// address, record start and free byte count go through one shared adder/comparator. The
// request side is ready only in the idle state; results sit in an output register, so the
// next request is taken while the last result still waits for its transfer. The store needs
// no initialization after reset: only bytes below the top offset are ever read.
`default_nettype none

module variable_record_byte_stack import vrbs_pkg::*; #(
    parameter int STORE_BYTES   = 1024,
    parameter int MAX_RECORD    = 64,
    parameter int TRAILER_BYTES = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    vrbs_in_if.sink           req,
    vrbs_out_if.source        rsp
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam int OW = $clog2(STORE_BYTES + 1);
    localparam int SW = ((OW > BYTE_W) ? OW : BYTE_W) + 1;
    localparam int TW = (TRAILER_BYTES > 1) ? $clog2(TRAILER_BYTES) : 1;

    localparam logic [SW-1:0]      STORE_X   = SW'(STORE_BYTES);
    localparam logic [SW-1:0]      TRL_X     = SW'(TRAILER_BYTES);
    localparam logic [OW-1:0]      TRL_O     = OW'(TRAILER_BYTES);
    localparam logic [TW-1:0]      TRL_LAST  = TW'(TRAILER_BYTES - 1);
    localparam logic [COUNT_W-1:0] MAX_C     = COUNT_W'(MAX_RECORD);
    localparam logic [BYTE_W-1:0]  MAX_B     = BYTE_W'(MAX_RECORD);

    // Sequencer state
    state_t               state_reg, state_next;
    logic [OPCODE_W-1:0]  op_reg, op_next;
    logic [BYTE_W-1:0]    data_reg, data_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    // Stack pointers and pending push
    logic [OW-1:0]        top_reg, top_next;
    logic [OW-1:0]        fill_reg, fill_next;
    logic [COUNT_W-1:0]   prog_reg, prog_next;
    logic                 rej_reg, rej_next;
    logic [TW-1:0]        tcnt_reg, tcnt_next;

    // Read run
    logic [OW-1:0]        base_reg, base_next;
    logic [OW-1:0]        ptr_reg, ptr_next;
    logic [BYTE_W-1:0]    len_reg, len_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [STATUS_W-1:0]  est_reg, est_next;

    // Result register
    logic                 ov_reg;
    logic [BYTE_W-1:0]    ob_reg;
    logic                 obv_reg;
    logic                 olast_reg;
    logic [STATUS_W-1:0]  ost_reg;
    logic                 oempty_reg;
    logic [FREE_W-1:0]    ofree_reg;

    // Byte store
    logic [BYTE_W-1:0]    mem [STORE_BYTES];
    logic [BYTE_W-1:0]    rd_data_reg;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [BYTE_W-1:0]    wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;

    // Shared arithmetic unit
    logic [SW-1:0]        alu_a, alu_b, alu_c, alu_sum;
    logic                 alu_sub, alu_gt;

    // Result load
    logic                 out_free;
    logic                 emit_en;
    logic [BYTE_W-1:0]    emit_byte;
    logic                 emit_bv;
    logic                 emit_last;
    logic [STATUS_W-1:0]  emit_st;
    logic [SW+FREE_W-1:0] free_ext;

    // Push and read helpers
    logic                 rej_now;
    logic [COUNT_W-1:0]   prog_inc;
    logic                 push_done;
    logic [BYTE_W-1:0]    lim_b;
    logic [BYTE_W-1:0]    min_b;
    logic [COUNT_W-1:0]   run_n;

    vrbs_alu #(.W(SW)) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .c   (alu_c),
        .sub (alu_sub),
        .sum (alu_sum),
        .gt  (alu_gt)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !ov_reg || rsp.ready;

    assign rsp.valid      = ov_reg;
    assign rsp.out_byte   = ob_reg;
    assign rsp.byte_valid = obv_reg;
    assign rsp.last       = olast_reg;
    assign rsp.status     = ost_reg;
    assign rsp.is_empty   = oempty_reg;
    assign rsp.free_bytes = ofree_reg;

    // Free bytes come from the shared unit's default operation (STORE_BYTES - top)
    assign free_ext = {{FREE_W{1'b0}}, alu_sum};

    // Copy length: min(limit, record length, MAX_RECORD)
    assign lim_b = {1'b0, count_reg};
    assign min_b = (len_reg < lim_b) ? len_reg : lim_b;
    assign run_n = (min_b > MAX_B) ? MAX_C : min_b[COUNT_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        data_next  = data_reg;
        count_next = count_reg;
        top_next   = top_reg;
        fill_next  = fill_reg;
        prog_next  = prog_reg;
        rej_next   = rej_reg;
        tcnt_next  = tcnt_reg;
        base_next  = base_reg;
        ptr_next   = ptr_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        est_next   = est_reg;

        wr_en   = 1'b0;
        wr_addr = fill_reg[AW-1:0];
        wr_data = data_reg;
        rd_en   = 1'b0;
        rd_addr = ptr_reg[AW-1:0];

        // default: free byte count for the result register
        alu_a   = STORE_X;
        alu_b   = SW'(top_reg);
        alu_c   = STORE_X;
        alu_sub = 1'b1;

        emit_en   = 1'b0;
        emit_byte = '0;
        emit_bv   = 1'b0;
        emit_last = 1'b1;
        emit_st   = est_reg;

        rej_now   = rej_reg;
        prog_inc  = prog_reg + COUNT_W'(1);
        push_done = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.opcode;
                    data_next  = req.data_byte;
                    count_next = req.byte_count;
                    est_next   = ST_OK;
                    if (req.opcode == OP_PUSH)
                    begin
                        state_next = (prog_reg == '0) ? S_PCHK : S_PBYTE;
                    end
                    else
                    begin
                        // any other operation drops a pending push
                        prog_next = '0;
                        rej_next  = 1'b0;
                        fill_next = top_reg;
                        case (req.opcode)
                            OP_POP, OP_PEEK:
                            begin
                                state_next = S_RD0;
                            end
                            OP_CLEAR:
                            begin
                                top_next   = '0;
                                fill_next  = '0;
                                state_next = S_EMIT;
                            end
                            default:
                            begin
                                state_next = S_EMIT;
                            end
                        endcase
                    end
                end
            end

            S_PCHK:
            begin
                // first item: whole record plus trailer must fit
                alu_a     = SW'(top_reg);
                alu_b     = SW'(count_reg) + TRL_X;
                alu_sub   = 1'b0;
                rej_now   = (count_reg > MAX_C) || alu_gt;
                fill_next = top_reg;
                if (count_reg == '0)
                begin
                    // zero-length push: trailer only
                    if (rej_now)
                    begin
                        rej_next   = 1'b0;
                        est_next   = ST_FULL;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        tcnt_next  = '0;
                        state_next = S_TRL;
                    end
                end
                else
                begin
                    rej_next   = rej_now;
                    state_next = S_PBYTE;
                end
            end

            S_PBYTE:
            begin
                alu_a   = SW'(fill_reg);
                alu_b   = SW'(1) + TRL_X;
                alu_sub = 1'b0;
                rej_now = rej_reg || (({1'b0, prog_reg} + BYTE_W'(1)) > MAX_B) || alu_gt;
                if (!rej_now)
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + OW'(1);
                end
                push_done = (prog_inc >= count_reg) || (prog_inc == '0);
                if (!push_done)
                begin
                    prog_next  = prog_inc;
                    rej_next   = rej_now;
                    state_next = S_IDLE;
                end
                else if (rej_now)
                begin
                    prog_next  = '0;
                    rej_next   = 1'b0;
                    fill_next  = top_reg;
                    est_next   = ST_FULL;
                    state_next = S_EMIT;
                end
                else
                begin
                    prog_next  = prog_inc;
                    rej_next   = 1'b0;
                    tcnt_next  = '0;
                    state_next = S_TRL;
                end
            end

            S_TRL:
            begin
                // length byte first, zeros after; fill ends on the new top
                wr_en     = 1'b1;
                wr_data   = (tcnt_reg == '0) ? {1'b0, prog_reg} : '0;
                fill_next = fill_reg + OW'(1);
                tcnt_next = tcnt_reg + TW'(1);
                if (tcnt_reg == TRL_LAST)
                begin
                    top_next   = fill_reg + OW'(1);
                    prog_next  = '0;
                    est_next   = ST_OK;
                    state_next = S_EMIT;
                end
            end

            S_RD0:
            begin
                if (top_reg < TRL_O)
                begin
                    est_next   = ST_EMPTY;
                    state_next = S_EMIT;
                end
                else
                begin
                    alu_a      = SW'(top_reg);
                    alu_b      = TRL_X;
                    alu_sub    = 1'b1;
                    base_next  = alu_sum[OW-1:0];
                    rd_en      = 1'b1;
                    rd_addr    = alu_sum[AW-1:0];
                    state_next = S_RD1;
                end
            end

            S_RD1:
            begin
                // clip a length longer than the bytes below the trailer
                alu_a      = SW'(rd_data_reg);
                alu_b      = '0;
                alu_c      = SW'(base_reg);
                alu_sub    = 1'b0;
                len_next   = alu_gt ? alu_c[BYTE_W-1:0] : rd_data_reg;
                state_next = S_RD2;
            end

            S_RD2:
            begin
                alu_a    = SW'(base_reg);
                alu_b    = SW'(len_reg);
                alu_sub  = 1'b1;
                ptr_next = alu_sum[OW-1:0];
                rem_next = run_n;
                if (op_reg == OP_POP)
                begin
                    top_next  = alu_sum[OW-1:0];
                    fill_next = alu_sum[OW-1:0];
                end
                if (run_n == '0)
                begin
                    est_next   = ST_OK;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_RD3;
                end
            end

            S_RD3:
            begin
                rd_en      = 1'b1;
                state_next = S_RD4;
            end

            S_RD4:
            begin
                if (out_free)
                begin
                    emit_en   = 1'b1;
                    emit_byte = rd_data_reg;
                    emit_bv   = 1'b1;
                    emit_last = (rem_reg == COUNT_W'(1));
                    emit_st   = ST_OK;
                    ptr_next  = ptr_reg + OW'(1);
                    rem_next  = rem_reg - COUNT_W'(1);
                    state_next = (rem_reg == COUNT_W'(1)) ? S_IDLE : S_RD3;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    emit_en    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            top_reg   <= '0;
            fill_reg  <= '0;
            prog_reg  <= '0;
            rej_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            fill_reg  <= fill_next;
            prog_reg  <= prog_next;
            rej_reg   <= rej_next;
            if (emit_en)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        data_reg  <= data_next;
        count_reg <= count_next;
        tcnt_reg  <= tcnt_next;
        base_reg  <= base_next;
        ptr_reg   <= ptr_next;
        len_reg   <= len_next;
        rem_reg   <= rem_next;
        est_reg   <= est_next;
        if (emit_en)
        begin
            ob_reg     <= emit_byte;
            obv_reg    <= emit_bv;
            olast_reg  <= emit_last;
            ost_reg    <= emit_st;
            oempty_reg <= (top_reg == '0);
            ofree_reg  <= free_ext[FREE_W-1:0];
        end
    end

    // Byte store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/vrbs_alu.sv
// Shared add/subtract unit with a greater-than compare on the result.
`default_nettype none

module vrbs_alu #(
    parameter int W = 12
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] c,
    input  logic         sub,
    output logic [W-1:0] sum,
    output logic         gt
);

    always_comb
    begin
        sum = sub ? (a - b) : (a + b);
        gt  = (sum > c);
    end

endmodule

`default_nettype wire

### rtl/core/vrbs_checker.sv
// Port-level checks on the variable record byte stack and their binding.
`default_nettype none

module vrbs_checker import vrbs_pkg::*; #(
    parameter int STORE_BYTES = 1024
) (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic [BYTE_W-1:0]   rsp_out_byte,
    input logic                rsp_byte_valid,
    input logic                rsp_last,
    input logic [STATUS_W-1:0] rsp_status,
    input logic                rsp_is_empty,
    input logic [FREE_W-1:0]   rsp_free_bytes
);

    // every request moves the sequencer out of the idle state
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request side ready right after a transfer");

    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_byte_valid |-> rsp_last && (rsp_out_byte == '0))
        else $error("status-only result without last or with a byte");

    a_copy_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_byte_valid |-> (rsp_status == ST_OK))
        else $error("copied byte with a non-ok status");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_is_empty)
        else $error("empty status on a non-empty stack");

    a_empty_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_empty |-> (rsp_free_bytes == FREE_W'(STORE_BYTES)))
        else $error("empty stack does not report the whole store free");

endmodule

bind variable_record_byte_stack vrbs_checker #(.STORE_BYTES(STORE_BYTES)) u_vrbs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_out_byte   (rsp.out_byte),
    .rsp_byte_valid (rsp.byte_valid),
    .rsp_last       (rsp.last),
    .rsp_status     (rsp.status),
    .rsp_is_empty   (rsp.is_empty),
    .rsp_free_bytes (rsp.free_bytes)
);

`default_nettype wire
